// File: hw/rtl/upd_pkg.sv
package upd_pkg;

  // Characters with a special meaning in URL encoding.
  localparam logic [7:0] CHAR_PCT   = 8'h25;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [3:0] HEX_ALPHA_BASE = 4'd10;

  // Output queue depth. One transaction may produce two results.
  localparam int unsigned OQ_DEPTH = 4;
  localparam int unsigned OQ_AW    = $clog2(OQ_DEPTH);
  localparam int unsigned OQ_CW    = $clog2(OQ_DEPTH + 1);

  // Decode phase, one-hot.
  typedef enum logic [2:0] {
    PH_PLAIN = 3'b001,
    PH_PCT   = 3'b010,
    PH_HEX1  = 3'b100
  } phase_e;

  // One decoded result.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } res_t;

  // Results of one decode step, compacted into the low slots.
  typedef struct packed {
    logic [1:0] cnt;
    res_t       res1;
    res_t       res0;
  } push_t;

  // Hex digit to nibble; anything that is not a hex digit reads as zero.
  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    logic [3:0] n;
    n = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      n = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      n = c[3:0] - 4'd1 + HEX_ALPHA_BASE;
    end
    return n;
  endfunction

  // Ordinary byte: plus becomes a space.
  function automatic logic [7:0] plain_of(input logic [7:0] c);
    return (c == CHAR_PLUS) ? CHAR_SPACE : c;
  endfunction

endpackage

// File: hw/rtl/url_percent_decoder.sv
// An accepted byte is held in the input register, then decoded and written into the output queue.
// Throughput: one input byte per cycle while the input is not stalled; the output queue takes
// up to two results per byte and drains one per cycle while the output is not stalled.
// Input stalls only when the four-entry output queue has fewer than two free entries.
// Reset (asynchronous, active low) empties the queue and returns decoding to plain text.
module url_percent_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);

  upd_pkg::push_t push;
  logic           room;

  // Input register and byte decoder.
  upd_decode u_decode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .room_i     (room),
    .push_o     (push)
  );

  // Result queue toward the output channel.
  upd_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o)
  );

endmodule

// File: hw/rtl/upd_decode.sv
module upd_decode (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [7:0]    in_byte_i,
  input  logic          in_last_i,
  input  logic          room_i,
  output upd_pkg::push_t push_o
);

  logic                stg_vld_q, stg_vld_d;
  logic [7:0]          stg_data_q;
  logic                stg_last_q;
  upd_pkg::phase_e     phase_q, phase_d;
  logic [7:0]          first_q, first_d;
  logic                adv;
  logic                load;
  upd_pkg::push_t      push;

  // The input register advances whenever the output queue has room for two results.
  assign adv        = stg_vld_q && room_i;
  assign in_stall_o = stg_vld_q && !room_i;
  assign load       = in_valid_i && !in_stall_o;
  assign stg_vld_d  = load || (stg_vld_q && !adv);

  // Decode one byte against the current phase.
  always_comb begin
    push       = '0;
    phase_d    = phase_q;
    first_d    = first_q;
    if (adv) begin
      case (phase_q)
        upd_pkg::PH_PCT: begin
          if (stg_last_q) begin
            push.cnt       = 2'd2;
            push.res0.data = upd_pkg::CHAR_PCT;
            push.res0.last = 1'b0;
            push.res1.data = upd_pkg::plain_of(stg_data_q);
            push.res1.last = 1'b1;
            phase_d        = upd_pkg::PH_PLAIN;
          end else begin
            first_d = stg_data_q;
            phase_d = upd_pkg::PH_HEX1;
          end
        end
        upd_pkg::PH_HEX1: begin
          push.cnt       = 2'd1;
          push.res0.data = {upd_pkg::nibble_of(first_q), upd_pkg::nibble_of(stg_data_q)};
          push.res0.last = stg_last_q;
          phase_d        = upd_pkg::PH_PLAIN;
        end
        default: begin
          if (stg_data_q == upd_pkg::CHAR_PCT && !stg_last_q) begin
            phase_d = upd_pkg::PH_PCT;
          end else begin
            push.cnt       = 2'd1;
            push.res0.data = upd_pkg::plain_of(stg_data_q);
            push.res0.last = stg_last_q;
            phase_d        = upd_pkg::PH_PLAIN;
          end
        end
      endcase
    end
  end

  assign push_o = push;

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_vld_q <= 1'b0;
      phase_q   <= upd_pkg::PH_PLAIN;
      first_q   <= '0;
    end else begin
      stg_vld_q <= stg_vld_d;
      phase_q   <= phase_d;
      first_q   <= first_d;
    end
  end

  // Input payload register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      stg_data_q <= in_byte_i;
      stg_last_q <= in_last_i;
    end
  end

  // Two results come only from a final byte.
  a_two_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.cnt == 2'd2 |-> stg_last_q) else $error("two results from a non-final byte");

  // A final byte always leaves the decoder in plain text.
  a_last_plain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && stg_last_q |=> phase_q == upd_pkg::PH_PLAIN)
    else $error("phase not plain after final byte");

  // A held input byte is not consumed while the queue has fewer than two free entries.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stg_vld_q && !room_i |=> stg_vld_q && $stable(stg_data_q))
    else $error("held input lost");

endmodule

// File: hw/rtl/upd_outq.sv
module upd_outq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  upd_pkg::push_t push_i,
  output logic           room_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [7:0]     out_byte_o,
  output logic           out_last_o
);

  upd_pkg::res_t                  mem_q [upd_pkg::OQ_DEPTH];
  logic [upd_pkg::OQ_AW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [upd_pkg::OQ_CW-1:0]      cnt_q, cnt_d;
  logic [upd_pkg::OQ_AW-1:0]      wr_ptr_nx;
  logic                           pop;

  // Room means two free entries, judged from the registered count.
  assign room_o      = cnt_q <= upd_pkg::OQ_CW'(upd_pkg::OQ_DEPTH - 2);
  assign out_valid_o = cnt_q != '0;
  assign pop         = out_valid_o && !out_stall_i;
  assign wr_ptr_nx   = wr_ptr_q + upd_pkg::OQ_AW'(1);
  assign cnt_d       = cnt_q + upd_pkg::OQ_CW'(push_i.cnt) - upd_pkg::OQ_CW'(pop);

  assign out_byte_o = mem_q[rd_ptr_q].data;
  assign out_last_o = mem_q[rd_ptr_q].last;

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + upd_pkg::OQ_AW'(push_i.cnt);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + upd_pkg::OQ_AW'(1);
      end
      cnt_q <= cnt_d;
    end
  end

  // Entry storage; a second result lands in the entry after the first.
  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.res0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_ptr_nx] <= push_i.res1;
    end
  end

  // The count never passes the depth.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= upd_pkg::OQ_CW'(upd_pkg::OQ_DEPTH)) else $error("output queue overflow");

  // Results are only pushed when room was signaled.
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.cnt != 2'd0 |-> room_o) else $error("push without room");

  // The count tracks pushes and pops.
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> cnt_q == $past(cnt_d)) else $error("count mismatch");

endmodule

// File: sim/tb_url_percent_decoder.sv
`timescale 1ns / 100ps

module tb_url_percent_decoder;

  // Clock, reset and the block's ports.
  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  logic [7:0] in_byte_i   = 8'h00;
  logic       in_last_i   = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] out_byte_o;
  logic       out_last_o;

  // Decoded bytes still owed by the block, oldest first.
  upd_pkg::res_t decoded_q[$];

  // Escape state of the predictor.
  upd_pkg::phase_e esc_phase = upd_pkg::PH_PLAIN;
  logic [7:0]      held_digit = 8'h00;

  // Idling in percent of cycles, and the receiver's long hold-off.
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  int unsigned cycle_cnt = 0;
  int unsigned hold_end  = 0;

  int unsigned error_cnt = 0;

  url_percent_decoder DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_byte_o (out_byte_o),
    .out_last_o (out_last_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #2_000_000;
    $display("** url_percent_decoder: FAILED **");
    $finish;
  end

  task automatic flag_error(input string msg);
    error_cnt++;
    if (error_cnt <= 10) begin
      $display("ERROR @%0t: %s", $realtime, msg);
    end
  endtask

  // Value of a hex digit character; any other character counts as zero.
  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c >= "0" && c <= "9") begin
      v = c - "0";
    end else if (c >= "a" && c <= "f") begin
      v = c - "a" + 8'd10;
    end else if (c >= "A" && c <= "F") begin
      v = c - "A" + 8'd10;
    end
    return v[3:0];
  endfunction

  function automatic logic [7:0] unplus(input logic [7:0] c);
    return (c == upd_pkg::CHAR_PLUS) ? upd_pkg::CHAR_SPACE : c;
  endfunction

  // Work out the decoded bytes that one accepted input byte releases.
  task automatic predict_decode(input logic [7:0] b, input logic l);
    case (esc_phase)
      upd_pkg::PH_PCT: begin
        if (l) begin
          // Escape cut short by the end of the string: percent goes out as is.
          decoded_q.push_back(upd_pkg::res_t'{data: upd_pkg::CHAR_PCT, last: 1'b0});
          decoded_q.push_back(upd_pkg::res_t'{data: unplus(b), last: 1'b1});
          esc_phase = upd_pkg::PH_PLAIN;
        end else begin
          held_digit = b;
          esc_phase  = upd_pkg::PH_HEX1;
        end
      end
      upd_pkg::PH_HEX1: begin
        decoded_q.push_back(upd_pkg::res_t'{data: {hex_value(held_digit), hex_value(b)},
                                            last: l});
        esc_phase = upd_pkg::PH_PLAIN;
      end
      default: begin
        if (b == upd_pkg::CHAR_PCT && !l) begin
          esc_phase = upd_pkg::PH_PCT;
        end else begin
          decoded_q.push_back(upd_pkg::res_t'{data: unplus(b), last: l});
          esc_phase = upd_pkg::PH_PLAIN;
        end
      end
    endcase
  endtask

  // Offer one byte after a random idle gap and wait until it is taken.
  task automatic send_byte(input logic [7:0] b, input logic l);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    in_last_i  <= l;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    predict_decode(b, l);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i], i == s.len() - 1);
    end
  endtask

  // Stop offering and wait until every owed byte has come out.
  task automatic wait_drained();
    int unsigned waited;
    waited = 0;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (decoded_q.size() != 0 && waited < 4000) begin
      @(posedge clk_i);
      waited++;
    end
    if (decoded_q.size() != 0) begin
      flag_error($sformatf("%0d decoded bytes never came out", decoded_q.size()));
      decoded_q.delete();
    end
  endtask

  // Mostly escape material, with some arbitrary bytes mixed in.
  function automatic logic [7:0] pick_text_byte();
    string       hex_chars;
    string       edge_chars;
    int unsigned sel;
    hex_chars  = "0123456789abcdefABCDEF";
    edge_chars = "/:@G`g";
    sel = $urandom_range(99);
    if (sel < 18) begin
      return upd_pkg::CHAR_PCT;
    end else if (sel < 26) begin
      return upd_pkg::CHAR_PLUS;
    end else if (sel < 58) begin
      return hex_chars[$urandom_range(hex_chars.len() - 1)];
    end else if (sel < 66) begin
      return edge_chars[$urandom_range(edge_chars.len() - 1)];
    end
    return 8'($urandom_range(255));
  endfunction

  // Random strings of short length, so string ends fall often near escapes.
  task automatic send_random_strings(input int unsigned n_items);
    int unsigned left;
    int unsigned len;
    left = n_items;
    while (left > 0) begin
      len = $urandom_range(1, 12);
      if (len > left) begin
        len = left;
      end
      for (int unsigned i = 0; i < len; i++) begin
        send_byte(pick_text_byte(), i == len - 1);
      end
      left -= len;
    end
  endtask

  // Directed strings: hex case mix, extremes, non-hex digits and cut-short escapes.
  task automatic test_directed();
    idle_pct  = 0;
    stall_pct = 0;
    send_text("%4a");
    send_text("%fF%00");
    send_text("a+b");
    send_text("%G/");
    send_text("%%+");
    send_text("%");
    send_text("%+");
    send_text("%%");
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    wait_drained();
  endtask

  task automatic test_random(input int unsigned n_items, input int unsigned idle,
                             input int unsigned stall);
    idle_pct  = idle;
    stall_pct = stall;
    send_random_strings(n_items);
    wait_drained();
  endtask

  // Receiver holds off while bytes keep coming, so the block has to stall its input.
  task automatic test_backpressure();
    idle_pct  = 0;
    stall_pct = 0;
    hold_end <= cycle_cnt + 80;
    send_random_strings(40);
    wait_drained();
  endtask

  // Receiver: random stalls, plus the long hold-off when one is requested.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    out_stall_i <= (cycle_cnt < hold_end) || ($urandom_range(99) < stall_pct);
  end

  // Compare each output transaction with the oldest owed byte.
  always @(posedge clk_i) begin
    upd_pkg::res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (decoded_q.size() == 0) begin
        flag_error($sformatf("unexpected output byte %h last %b", out_byte_o, out_last_o));
      end else begin
        want = decoded_q.pop_front();
        if (out_byte_o !== want.data || out_last_o !== want.last) begin
          flag_error($sformatf("byte %h last %b, expected byte %h last %b",
                               out_byte_o, out_last_o, want.data, want.last));
        end
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random(450, 0, 0);
    test_random(450, 64, 0);
    test_random(450, 0, 64);
    test_random(450, 19, 19);
    test_backpressure();

    repeat (10) @(posedge clk_i);
    if (error_cnt == 0) begin
      $display("** url_percent_decoder: PASSED **");
    end else begin
      $display("** url_percent_decoder: FAILED **");
    end
    $finish;
  end

endmodule
